FILE: hw/rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg: shared definitions for the parallel command framer
// Opcodes, command codes, frame builder and the status struct between the
// sequencer and the top level.
// ----------------------------------------------------------------------------
package pcf_pkg;

    // Longest frame any command produces: opcode, six payload bytes, checksum
    localparam int FRAME_BYTES_MAX = 8;
    localparam int FRAME_MAX_DEF   = 8;
    localparam int LEN_W           = 4;

    // Command codes on the request channel
    localparam logic [2:0] CMD_HALT      = 3'd0;
    localparam logic [2:0] CMD_PLAY      = 3'd1;
    localparam logic [2:0] CMD_DELETE    = 3'd2;
    localparam logic [2:0] CMD_AMPS      = 3'd3;
    localparam logic [2:0] CMD_FREQUENCY = 3'd4;
    localparam logic [2:0] CMD_LEFT_AMP  = 3'd5;
    localparam logic [2:0] CMD_RIGHT_AMP = 3'd6;

    // Item kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_SAMPLE  = 1'b1;

    // Opcodes sent as the first frame byte
    localparam logic [7:0] OP_STOP      = 8'hF0;
    localparam logic [7:0] OP_START     = 8'hF1;
    localparam logic [7:0] OP_DELETE    = 8'hF7;
    localparam logic [7:0] OP_AMPS      = 8'hF9;
    localparam logic [7:0] OP_FREQUENCY = 8'hFB;
    localparam logic [7:0] OP_LEFT_AMP  = 8'hFC;
    localparam logic [7:0] OP_RIGHT_AMP = 8'hFD;
    localparam logic [7:0] DELETE_ALL_INDEX = 8'hAA;

    typedef logic [FRAME_BYTES_MAX-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;    // zero when the command has no meaning
        frame_bytes_t     bytes;  // byte i of the frame in bytes[i]
    } frame_build_t;

    // Sequencer status for the step being taken
    typedef struct packed {
        logic load;       // a new frame is latched this step
        logic loaded;     // a frame has been latched since reset
        logic strobe;     // write level after the step
        logic done;       // last byte handshake completed
        logic executed;   // partner accepted the frame
        logic busy;       // transfer in progress after the step
        logic dropped;    // request came in while busy
    } seq_info_t;

    function automatic frame_build_t build_frame(
        input logic [2:0]  cmd,
        input logic [15:0] idx,
        input logic        dall,
        input logic [15:0] al,
        input logic [15:0] ar
    );
        frame_build_t f;
        logic [7:0]   sum;
        logic [LEN_W-1:0] n;
        f.bytes = '0;
        n       = '0;
        sum     = '0;
        case (cmd)
            CMD_HALT:
            begin
                f.bytes[0] = OP_STOP;
                n = LEN_W'(1);
            end
            CMD_PLAY:
            begin
                f.bytes[0] = OP_START;
                f.bytes[1] = idx[7:0];
                f.bytes[2] = idx[15:8];
                f.bytes[3] = al[7:0];
                f.bytes[4] = al[15:8];
                f.bytes[5] = ar[7:0];
                f.bytes[6] = ar[15:8];
                n = LEN_W'(7);
            end
            CMD_DELETE:
            begin
                f.bytes[0] = OP_DELETE;
                f.bytes[1] = dall ? DELETE_ALL_INDEX : idx[7:0];
                n = LEN_W'(2);
            end
            CMD_AMPS:
            begin
                f.bytes[0] = OP_AMPS;
                f.bytes[1] = al[7:0];
                f.bytes[2] = al[15:8];
                f.bytes[3] = ar[7:0];
                f.bytes[4] = ar[15:8];
                n = LEN_W'(5);
            end
            CMD_FREQUENCY:
            begin
                f.bytes[0] = OP_FREQUENCY;
                f.bytes[1] = idx[7:0];
                f.bytes[2] = idx[15:8];
                n = LEN_W'(3);
            end
            CMD_LEFT_AMP:
            begin
                f.bytes[0] = OP_LEFT_AMP;
                f.bytes[1] = al[7:0];
                f.bytes[2] = al[15:8];
                n = LEN_W'(3);
            end
            CMD_RIGHT_AMP:
            begin
                f.bytes[0] = OP_RIGHT_AMP;
                f.bytes[1] = ar[7:0];
                f.bytes[2] = ar[15:8];
                n = LEN_W'(3);
            end
            default:
            begin
                n = '0;
            end
        endcase
        // unused bytes are zero, so summing all seven is the checksum
        for (int i = 0; i < FRAME_BYTES_MAX - 1; i++) begin
            sum = sum + f.bytes[i];
        end
        for (int i = 1; i < FRAME_BYTES_MAX; i++) begin
            if (LEN_W'(i) == n) begin
                f.bytes[i] = sum;
            end
        end
        f.len = (n == '0) ? '0 : n + LEN_W'(1);
        return f;
    endfunction

endpackage

FILE: hw/rtl/parallel_command_framer_unit.sv
// ----------------------------------------------------------------------------
// parallel_command_framer_unit: command framer for a byte-wide parallel link
// Every input transfer is either a command request or a sample of the
// partner's latched line; each yields exactly one result transfer that
// carries the data byte, the write strobe level and the frame status. The
// unit takes one input transfer per clock and its result is registered in
// the output register in the cycle after; a new input is taken while a
// result waits as long as out_ready is high that cycle, so the rate is one
// item per cycle, set by the single output register. The real frame pace is
// set by how fast the partner answers the write/latched handshake.
// ----------------------------------------------------------------------------
module parallel_command_framer_unit #(
    parameter int FRAME_MAX = pcf_pkg::FRAME_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request / sample channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [2:0]         command,
    input  logic [15:0]        clip_index,
    input  logic               purge_all,
    input  logic signed [15:0] amp_left,
    input  logic signed [15:0] amp_right,
    input  logic               latched,
    input  logic               not_exec,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         bus_byte,
    output logic               write_level,
    output logic               frame_done,
    output logic               executed,
    output logic               busy_res,
    output logic               request_dropped
);

    localparam int DEPTH = (FRAME_MAX < pcf_pkg::FRAME_BYTES_MAX) ?
                           FRAME_MAX : pcf_pkg::FRAME_BYTES_MAX;
    localparam int IDX_W = $clog2(DEPTH);

    logic                        accept;
    logic [pcf_pkg::LEN_W-1:0]   build_len;
    logic [IDX_W-1:0]            pos_next;
    logic [7:0]                  rd_byte;
    pcf_pkg::seq_info_t          info;

    logic       out_valid_reg;
    logic [7:0] bus_byte_reg;
    logic       write_level_reg;
    logic       frame_done_reg;
    logic       executed_reg;
    logic       busy_res_reg;
    logic       dropped_reg;

    // Take a new transfer whenever the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pcf_frame_store #(
        .FRAME_MAX (FRAME_MAX)
    ) u_store (
        .clk         (clk),
        .command     (command),
        .clip_index  (clip_index),
        .purge_all   (purge_all),
        .amp_left    (amp_left),
        .amp_right   (amp_right),
        .load        (info.load),
        .rd_pos      (pos_next),
        .build_len   (build_len),
        .rd_byte     (rd_byte)
    );

    pcf_seq #(
        .FRAME_MAX (FRAME_MAX)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .latched   (latched),
        .not_exec  (not_exec),
        .build_len (build_len),
        .info      (info),
        .pos_next  (pos_next)
    );

    // Hold a result until taken; drop valid once it leaves with no new one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; the bus shows zero until the first frame is latched
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bus_byte_reg    <= info.loaded ? rd_byte : 8'h00;
            write_level_reg <= info.strobe;
            frame_done_reg  <= info.done;
            executed_reg    <= info.executed;
            busy_res_reg    <= info.busy;
            dropped_reg     <= info.dropped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign bus_byte        = bus_byte_reg;
    assign write_level     = write_level_reg;
    assign frame_done      = frame_done_reg;
    assign executed        = executed_reg;
    assign busy_res        = busy_res_reg;
    assign request_dropped = dropped_reg;

    // A completed frame leaves the unit idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> !busy_res_reg)
        else $error("frame_done reported while still busy");

    // Executed only comes with the completion pulse
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && executed_reg |-> frame_done_reg)
        else $error("executed without frame_done");

    // A dropped request leaves the running transfer untouched
    a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dropped_reg |-> busy_res_reg && !frame_done_reg)
        else $error("dropped request while idle");

    // Write is only raised inside a transfer
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && write_level_reg |-> busy_res_reg)
        else $error("write strobe high outside a transfer");

endmodule

FILE: hw/rtl/pcf_frame_store.sv
// ----------------------------------------------------------------------------
// pcf_frame_store: frame builder and byte store
// Builds the frame for a request and holds its bytes for the transfer.
// ----------------------------------------------------------------------------
module pcf_frame_store #(
    parameter int FRAME_MAX = pcf_pkg::FRAME_MAX_DEF,
    localparam int DEPTH = (FRAME_MAX < pcf_pkg::FRAME_BYTES_MAX) ?
                           FRAME_MAX : pcf_pkg::FRAME_BYTES_MAX,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic [2:0]                  command,
    input  logic [15:0]                 clip_index,
    input  logic                        purge_all,
    input  logic signed [15:0]          amp_left,
    input  logic signed [15:0]          amp_right,
    input  logic                        load,
    input  logic [IDX_W-1:0]            rd_pos,
    output logic [pcf_pkg::LEN_W-1:0]   build_len,
    output logic [7:0]                  rd_byte
);

    pcf_pkg::frame_build_t build;
    logic [7:0] bytes_reg [DEPTH];

    assign build = pcf_pkg::build_frame(command, clip_index, purge_all,
                                        amp_left, amp_right);
    assign build_len = build.len;

    // Hold the frame bytes; only positions of the current frame are read
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < DEPTH; i++) begin
                bytes_reg[i] <= build.bytes[i];
            end
        end
    end

    // A new frame always starts at its opcode
    assign rd_byte = load ? build.bytes[0] : bytes_reg[rd_pos];

endmodule

FILE: hw/rtl/pcf_seq.sv
// ----------------------------------------------------------------------------
// pcf_seq: four-phase handshake sequencer
// Tracks byte position, write strobe and the partner's verdict per frame.
// ----------------------------------------------------------------------------
module pcf_seq #(
    parameter int FRAME_MAX = pcf_pkg::FRAME_MAX_DEF,
    localparam int DEPTH = (FRAME_MAX < pcf_pkg::FRAME_BYTES_MAX) ?
                           FRAME_MAX : pcf_pkg::FRAME_BYTES_MAX,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        kind,
    input  logic                        latched,
    input  logic                        not_exec,
    input  logic [pcf_pkg::LEN_W-1:0]   build_len,
    output pcf_pkg::seq_info_t          info,
    output logic [IDX_W-1:0]            pos_next
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_HIGH,
        PH_WAIT_LOW
    } phase_t;

    localparam logic [pcf_pkg::LEN_W-1:0] DEPTH_L = pcf_pkg::LEN_W'(DEPTH);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             loaded_reg, loaded_next;
    logic             strobe_reg, strobe_next;
    logic             rejected_reg, rejected_next;
    logic             at_last;

    assign at_last = (pos_reg == last_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        last_next     = last_reg;
        loaded_next   = loaded_reg;
        strobe_next   = strobe_reg;
        rejected_next = rejected_reg;
        info          = '0;
        if (accept)
        begin
            if (kind == pcf_pkg::KIND_REQUEST)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    info.dropped = 1'b1;
                end
                else if (build_len != '0 && build_len <= DEPTH_L)
                begin
                    info.load     = 1'b1;
                    pos_next      = '0;
                    last_next     = IDX_W'(build_len - pcf_pkg::LEN_W'(1));
                    loaded_next   = 1'b1;
                    rejected_next = 1'b0;
                    strobe_next   = 1'b1;
                    phase_next    = PH_WAIT_HIGH;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT_HIGH:
                    begin
                        if (latched)
                        begin
                            if (at_last)
                            begin
                                rejected_next = not_exec;
                            end
                            strobe_next = 1'b0;
                            phase_next  = PH_WAIT_LOW;
                        end
                    end
                    PH_WAIT_LOW:
                    begin
                        if (!latched)
                        begin
                            if (at_last)
                            begin
                                info.done     = 1'b1;
                                info.executed = !rejected_reg;
                                phase_next    = PH_IDLE;
                            end
                            else
                            begin
                                pos_next    = pos_reg + IDX_W'(1);
                                strobe_next = 1'b1;
                                phase_next  = PH_WAIT_HIGH;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        info.loaded = loaded_next;
        info.strobe = strobe_next;
        info.busy   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            last_reg     <= '0;
            loaded_reg   <= 1'b0;
            strobe_reg   <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            last_reg     <= last_next;
            loaded_reg   <= loaded_next;
            strobe_reg   <= strobe_next;
            rejected_reg <= rejected_next;
        end
    end

endmodule

FILE: test/framer_tb_pkg.sv
// ----------------------------------------------------------------------------
// framer_tb_pkg: scoreboard for the parallel command framer
// Transfer types and a scoreboard class that predicts the status of every
// accepted transfer and checks each result against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package framer_tb_pkg;

    localparam int         FRAME_LIMIT   = pcf_pkg::FRAME_MAX_DEF;
    localparam logic [2:0] CMD_UNDEFINED = 3'd7;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT_HIGH,
        LINK_WAIT_LOW
    } link_phase_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  command;
        logic [15:0] clip_index;
        logic        purge_all;
        logic [15:0] amp_left;
        logic [15:0] amp_right;
        logic        latched;
        logic        not_exec;
    } link_item_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       write_level;
        logic       frame_done;
        logic       executed;
        logic       busy_res;
        logic       request_dropped;
    } link_status_t;

    typedef struct {
        link_item_t item;
        bit         when_idle;
    } directed_t;

    class framer_scoreboard_t;

        link_phase_t  phase;
        logic [7:0]   frame [FRAME_LIMIT];
        int           frame_len;
        int           byte_pos;
        logic         strobe;
        logic         refused;
        link_status_t expected_q [$];
        int           errors;

        function new();
            phase     = LINK_IDLE;
            frame_len = 0;
            byte_pos  = 0;
            strobe    = 1'b0;
            refused   = 1'b0;
            errors    = 0;
            foreach (frame[i])
            begin
                frame[i] = 8'h00;
            end
        endfunction

        function bit busy();
            return phase != LINK_IDLE;
        endfunction

        function bit wants_latch_high();
            return phase == LINK_WAIT_HIGH;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Build opcode, payload and checksum; refuse undefined or oversize frames.
        function bit load_frame(link_item_t it);
            logic [7:0] b [8];
            int         n;
            logic [7:0] sum;
            n   = 0;
            sum = 8'h00;
            case (it.command)
                pcf_pkg::CMD_HALT:
                begin
                    b[0] = pcf_pkg::OP_STOP;
                    n = 1;
                end
                pcf_pkg::CMD_PLAY:
                begin
                    b[0] = pcf_pkg::OP_START;
                    b[1] = it.clip_index[7:0];
                    b[2] = it.clip_index[15:8];
                    b[3] = it.amp_left[7:0];
                    b[4] = it.amp_left[15:8];
                    b[5] = it.amp_right[7:0];
                    b[6] = it.amp_right[15:8];
                    n = 7;
                end
                pcf_pkg::CMD_DELETE:
                begin
                    b[0] = pcf_pkg::OP_DELETE;
                    b[1] = it.purge_all ? pcf_pkg::DELETE_ALL_INDEX
                                        : it.clip_index[7:0];
                    n = 2;
                end
                pcf_pkg::CMD_AMPS:
                begin
                    b[0] = pcf_pkg::OP_AMPS;
                    b[1] = it.amp_left[7:0];
                    b[2] = it.amp_left[15:8];
                    b[3] = it.amp_right[7:0];
                    b[4] = it.amp_right[15:8];
                    n = 5;
                end
                pcf_pkg::CMD_FREQUENCY:
                begin
                    b[0] = pcf_pkg::OP_FREQUENCY;
                    b[1] = it.clip_index[7:0];
                    b[2] = it.clip_index[15:8];
                    n = 3;
                end
                pcf_pkg::CMD_LEFT_AMP:
                begin
                    b[0] = pcf_pkg::OP_LEFT_AMP;
                    b[1] = it.amp_left[7:0];
                    b[2] = it.amp_left[15:8];
                    n = 3;
                end
                pcf_pkg::CMD_RIGHT_AMP:
                begin
                    b[0] = pcf_pkg::OP_RIGHT_AMP;
                    b[1] = it.amp_right[7:0];
                    b[2] = it.amp_right[15:8];
                    n = 3;
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
            if (n + 1 > FRAME_LIMIT)
            begin
                return 1'b0;
            end
            for (int i = 0; i < n; i++)
            begin
                frame[i] = b[i];
                sum = sum + b[i];
            end
            frame[n]  = sum;
            frame_len = n + 1;
            return 1'b1;
        endfunction

        // Advance the link state by one transfer and queue the status it yields.
        function void note_transfer(link_item_t it);
            link_status_t s;
            bit           last;
            s    = '0;
            last = (byte_pos + 1 >= frame_len);
            if (it.kind == pcf_pkg::KIND_REQUEST)
            begin
                if (phase != LINK_IDLE)
                begin
                    s.request_dropped = 1'b1;
                end
                else if (load_frame(it))
                begin
                    byte_pos = 0;
                    refused  = 1'b0;
                    strobe   = 1'b1;
                    phase    = LINK_WAIT_HIGH;
                end
            end
            else if (phase == LINK_WAIT_HIGH)
            begin
                if (it.latched)
                begin
                    if (last)
                    begin
                        refused = it.not_exec;
                    end
                    strobe = 1'b0;
                    phase  = LINK_WAIT_LOW;
                end
            end
            else if (phase == LINK_WAIT_LOW)
            begin
                if (!it.latched)
                begin
                    if (last)
                    begin
                        s.frame_done = 1'b1;
                        s.executed   = !refused;
                        phase        = LINK_IDLE;
                    end
                    else
                    begin
                        byte_pos++;
                        strobe = 1'b1;
                        phase  = LINK_WAIT_HIGH;
                    end
                end
            end
            if (frame_len != 0 && byte_pos < frame_len && byte_pos < FRAME_LIMIT)
            begin
                s.bus_byte = frame[byte_pos];
            end
            s.write_level = strobe;
            s.busy_res    = (phase != LINK_IDLE);
            expected_q.push_back(s);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(link_status_t got);
            link_status_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, bus_byte %0h",
                         $time, got.bus_byte);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("bus_byte", want.bus_byte, got.bus_byte);
            compare_field("write_level", 8'(want.write_level), 8'(got.write_level));
            compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
            compare_field("executed", 8'(want.executed), 8'(got.executed));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("request_dropped", 8'(want.request_dropped),
                          8'(got.request_dropped));
        endfunction

    endclass

endpackage

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for parallel_command_framer_unit
// Drives command requests and partner handshake samples, directed first and
// then random, with bursty input and a stalling receiver, and checks every
// result transfer against a scoreboard prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // Stop offering once this many input transfers have been accepted.
    localparam int ITEM_TOTAL     = 1520;
    // Hold the sender at this count until every result has drained.
    localparam int PAUSE_AT       = 1000;
    // Receiver hold-off window, in receiver cycles, long enough to back up
    // the output register and stall the input channel.
    localparam int HOLD_START     = 800;
    localparam int HOLD_LEN       = 300;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last result before the verdict.
    localparam int DRAIN_CYCLES   = 20;

    // Receiver stall patterns, rotated in turn.
    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_COMB  = 2;
    localparam int RX_HEAVY = 3;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_ready;
    logic               kind            = 1'b0;
    logic [2:0]         command         = 3'd0;
    logic [15:0]        clip_index      = 16'h0000;
    logic               purge_all       = 1'b0;
    logic signed [15:0] amp_left        = 16'sh0000;
    logic signed [15:0] amp_right       = 16'sh0000;
    logic               latched         = 1'b0;
    logic               not_exec        = 1'b0;
    logic               out_valid;
    logic               out_ready       = 1'b0;
    logic [7:0]         bus_byte;
    logic               write_level;
    logic               frame_done;
    logic               executed;
    logic               busy_res;
    logic               request_dropped;

    framer_tb_pkg::framer_scoreboard_t sb;
    framer_tb_pkg::directed_t          directed_q [$];
    framer_tb_pkg::link_item_t         cur;
    framer_tb_pkg::link_status_t       seen;
    int               accepted    = 0;
    int               gap_left    = 0;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    int               drain       = 0;
    int               rx_cycle    = 0;
    bit               stim_done   = 1'b0;
    bit               pause_done  = 1'b0;
    bit               timed_out   = 1'b0;
    bit               run_over    = 1'b0;
    bit               moved;

    parallel_command_framer_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .command         (command),
        .clip_index      (clip_index),
        .purge_all       (purge_all),
        .amp_left        (amp_left),
        .amp_right       (amp_right),
        .latched         (latched),
        .not_exec        (not_exec),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bus_byte        (bus_byte),
        .write_level     (write_level),
        .frame_done      (frame_done),
        .executed        (executed),
        .busy_res        (busy_res),
        .request_dropped (request_dropped)
    );

    always #5 clk = ~clk;

    // Queue one directed transfer. With when_idle set, the sender first
    // completes the frame in flight with clean handshakes, then issues it.
    task automatic add_directed(logic k, logic [2:0] c, logic [15:0] idx, logic dall,
                                logic [15:0] al, logic [15:0] ar, logic lat, logic nx,
                                bit when_idle);
        framer_tb_pkg::directed_t d;
        d.item.kind        = k;
        d.item.command     = c;
        d.item.clip_index  = idx;
        d.item.purge_all   = dall;
        d.item.amp_left    = al;
        d.item.amp_right   = ar;
        d.item.latched     = lat;
        d.item.not_exec    = nx;
        d.when_idle        = when_idle;
        directed_q.push_back(d);
    endtask

    task automatic build_directed();
        // sample while idle, then an undefined command: both leave the link idle
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        add_directed(pcf_pkg::KIND_REQUEST, framer_tb_pkg::CMD_UNDEFINED, 16'hFFFF, 1'b1,
                     16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // stop frame walked by hand: repeated levels, a request while busy,
        // and a refusal on the last byte
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_PLAY, 16'h1234, 1'b0,
                     16'h5678, 16'h9ABC, 1'b0, 1'b0, 1'b0);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
        add_directed(pcf_pkg::KIND_SAMPLE, pcf_pkg::CMD_HALT, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        // every command at the edges of its fields
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_DELETE, 16'h1234, 1'b1,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_DELETE, 16'hABFF, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_PLAY, 16'hFFFF, 1'b0,
                     16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_PLAY, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_AMPS, 16'h0000, 1'b0,
                     16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_AMPS, 16'h0000, 1'b0,
                     16'hFFFF, 16'h8000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_FREQUENCY, 16'hFFFF, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_FREQUENCY, 16'h0000, 1'b0,
                     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_LEFT_AMP, 16'h0000, 1'b0,
                     16'h8000, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_LEFT_AMP, 16'h0000, 1'b0,
                     16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_RIGHT_AMP, 16'h0000, 1'b0,
                     16'h0000, 16'h8000, 1'b0, 1'b0, 1'b1);
        add_directed(pcf_pkg::KIND_REQUEST, pcf_pkg::CMD_RIGHT_AMP, 16'h0000, 1'b0,
                     16'h0000, 16'h7FFF, 1'b0, 1'b0, 1'b1);
    endtask

    // Choose the next transfer from the predicted link state. Most random
    // traffic is a correct handshake so frames run to completion; the rest is
    // repeated levels, requests while busy, undefined commands and idle samples.
    task automatic pick_item(output framer_tb_pkg::link_item_t it);
        int                       r;
        framer_tb_pkg::directed_t d;
        it.kind        = 1'($urandom_range(0, 1));
        it.command     = 3'($urandom_range(0, 6));
        it.clip_index  = 16'($urandom);
        it.purge_all   = 1'($urandom_range(0, 1));
        it.amp_left    = 16'($urandom);
        it.amp_right   = 16'($urandom);
        it.latched     = 1'($urandom_range(0, 1));
        it.not_exec    = 1'($urandom_range(0, 1));
        if (directed_q.size() != 0)
        begin
            if (directed_q[0].when_idle && sb.busy())
            begin
                it.kind     = pcf_pkg::KIND_SAMPLE;
                it.latched  = sb.wants_latch_high();
                it.not_exec = 1'b0;
            end
            else
            begin
                d  = directed_q.pop_front();
                it = d.item;
            end
            return;
        end
        r = $urandom_range(0, 99);
        if (!sb.busy())
        begin
            if (r < 6)
            begin
                it.kind = pcf_pkg::KIND_SAMPLE;
            end
            else if (r < 10)
            begin
                it.kind    = pcf_pkg::KIND_REQUEST;
                it.command = framer_tb_pkg::CMD_UNDEFINED;
            end
            else
            begin
                it.kind = pcf_pkg::KIND_REQUEST;
            end
        end
        else if (r < 5)
        begin
            it.kind = pcf_pkg::KIND_REQUEST;
        end
        else
        begin
            it.kind    = pcf_pkg::KIND_SAMPLE;
            it.latched = (r < 20) ? !sb.wants_latch_high() : sb.wants_latch_high();
        end
    endtask

    // Sender: hold the payload while a transfer is pending, otherwise offer
    // the next item in bursts separated by random gaps.
    task automatic drive_sender();
        if (in_valid && !in_ready)
        begin
            return;
        end
        if (accepted >= ITEM_TOTAL)
        begin
            in_valid  <= 1'b0;
            stim_done  = 1'b1;
            return;
        end
        // pause once until the result channel has fully drained
        if (accepted >= PAUSE_AT && !pause_done)
        begin
            if (sb.pending() != 0)
            begin
                in_valid <= 1'b0;
                return;
            end
            pause_done = 1'b1;
        end
        if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
            return;
        end
        pick_item(cur);
        kind        <= cur.kind;
        command     <= cur.command;
        clip_index  <= cur.clip_index;
        purge_all   <= cur.purge_all;
        amp_left    <= cur.amp_left;
        amp_right   <= cur.amp_right;
        latched     <= cur.latched;
        not_exec    <= cur.not_exec;
        in_valid    <= 1'b1;
        if (burst_left > 1)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    // Receiver: rotate through stall patterns, with one long hold-off that
    // lets the output register fill and back-pressure the input.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 64) % 4)
                RX_FREE:  out_ready <= 1'b1;
                RX_LIGHT: out_ready <= ($urandom_range(0, 2) != 0);
                RX_COMB:  out_ready <= ((rx_cycle % 4) != 0);
                RX_HEAVY: out_ready <= ($urandom_range(0, 2) == 0);
                default:  out_ready <= 1'b1;
            endcase
        end
    end

    // Main process: release reset, then per clock record transfers on both
    // channels, advance the sender, and watch for a hang or the end.
    initial
    begin
        sb = new();
        build_directed();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!run_over)
        begin
            @(posedge clk);
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                seen.bus_byte        = bus_byte;
                seen.write_level     = write_level;
                seen.frame_done      = frame_done;
                seen.executed        = executed;
                seen.busy_res        = busy_res;
                seen.request_dropped = request_dropped;
                sb.check_status(seen);
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                sb.note_transfer(cur);
                accepted++;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, sb.pending());
                timed_out = 1'b1;
                run_over  = 1'b1;
            end
            else
            begin
                drive_sender();
                if (stim_done && sb.pending() == 0)
                begin
                    drain++;
                    if (drain >= DRAIN_CYCLES)
                    begin
                        run_over = 1'b1;
                    end
                end
            end
        end
        if (!timed_out && sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
